/* sv/msb_pkg.sv */
package msb_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 16;
  localparam int IDX_BITS   = $clog2(DEPTH);
  localparam int CNT_BITS   = $clog2(DEPTH + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  // Memory access request from the merge engine
  typedef struct packed {
    idx_t   rd_a;
    idx_t   rd_b;
    logic   wr_en;
    idx_t   wr_addr;
    value_t wr_data;
  } ram_req_t;

  // Merge engine status toward the top level
  typedef struct packed {
    logic done;
    logic bank;
  } sort_stat_t;

endpackage

/* sv/msb_in_if.sv */
interface msb_in_if;
  logic            valid;
  logic            ready;
  msb_pkg::value_t value;
  logic            final_item;

  modport source(output valid, value, final_item, input ready);
  modport sink(input valid, value, final_item, output ready);
endinterface

/* sv/msb_out_if.sv */
interface msb_out_if;
  logic            valid;
  logic            ready;
  msb_pkg::value_t sorted_value;
  logic            last_out;

  modport source(output valid, sorted_value, last_out, input ready);
  modport sink(input valid, sorted_value, last_out, output ready);
endinterface

/* sv/msb_ram.sv */
module msb_ram #(
  parameter int DEPTH_P = 64,
  parameter int WIDTH_P = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH_P)-1:0] waddr,
  input  logic [WIDTH_P-1:0]         wdata,
  input  logic [$clog2(DEPTH_P)-1:0] raddr_a,
  input  logic [$clog2(DEPTH_P)-1:0] raddr_b,
  output logic [WIDTH_P-1:0]         rdata_a,
  output logic [WIDTH_P-1:0]         rdata_b
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // One write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* sv/msb_merge.sv */
module msb_merge (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  msb_pkg::cnt_t       n,
  input  msb_pkg::value_t     rdata_a,
  input  msb_pkg::value_t     rdata_b,
  output msb_pkg::ram_req_t   req,
  output msb_pkg::sort_stat_t stat
);

  typedef enum logic [1:0] {S_IDLE, S_SETUP, S_MERGE, S_DONE} state_t;
  typedef logic [msb_pkg::CNT_BITS:0] sum_t;

  state_t        state;
  msb_pkg::cnt_t n_r;
  msb_pkg::cnt_t w;
  msb_pkg::cnt_t lo;
  msb_pkg::cnt_t i;
  msb_pkg::cnt_t j;
  msb_pkg::cnt_t a_end;
  msb_pkg::cnt_t b_end;
  msb_pkg::cnt_t k;
  logic          bank;

  sum_t          lo_w;
  sum_t          lo_2w;
  sum_t          w2;
  msb_pkg::cnt_t a_end_c;
  msb_pkg::cnt_t b_end_c;
  logic          a_ok;
  logic          b_ok;
  logic          take_a;
  msb_pkg::cnt_t i_next;
  msb_pkg::cnt_t j_next;
  msb_pkg::cnt_t k_next;

  // Bounds of the next pair of runs, clipped to the set size
  always_comb begin
    lo_w    = sum_t'(lo) + sum_t'(w);
    lo_2w   = lo_w + sum_t'(w);
    w2      = sum_t'(w) << 1;
    a_end_c = (lo_w > sum_t'(n_r)) ? n_r : lo_w[msb_pkg::CNT_BITS-1:0];
    b_end_c = (lo_2w > sum_t'(n_r)) ? n_r : lo_2w[msb_pkg::CNT_BITS-1:0];
  end

  // Pick the smaller head, left run on ties
  always_comb begin
    a_ok   = i < a_end;
    b_ok   = j < b_end;
    take_a = a_ok && (!b_ok || (rdata_a <= rdata_b));
    i_next = i + msb_pkg::cnt_t'(take_a);
    j_next = j + msb_pkg::cnt_t'(!take_a);
    k_next = k + msb_pkg::cnt_t'(1);
  end

  // Read the next heads, write the chosen element to the other bank
  always_comb begin
    req.rd_a    = i[msb_pkg::IDX_BITS-1:0];
    req.rd_b    = j[msb_pkg::IDX_BITS-1:0];
    req.wr_en   = 1'b0;
    req.wr_addr = k[msb_pkg::IDX_BITS-1:0];
    req.wr_data = take_a ? rdata_a : rdata_b;
    unique case (state)
      S_SETUP: begin
        req.rd_a = lo[msb_pkg::IDX_BITS-1:0];
        req.rd_b = a_end_c[msb_pkg::IDX_BITS-1:0];
      end
      S_MERGE: begin
        req.rd_a  = i_next[msb_pkg::IDX_BITS-1:0];
        req.rd_b  = j_next[msb_pkg::IDX_BITS-1:0];
        req.wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign stat.done = (state == S_DONE);
  assign stat.bank = bank;

  // Pass sequencer: run width doubles after each full pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      bank  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n_r   <= n;
            w     <= msb_pkg::cnt_t'(1);
            lo    <= '0;
            bank  <= 1'b0;
            state <= (n <= msb_pkg::cnt_t'(1)) ? S_DONE : S_SETUP;
          end
        end
        S_SETUP: begin
          i     <= lo;
          j     <= a_end_c;
          a_end <= a_end_c;
          b_end <= b_end_c;
          k     <= lo;
          state <= S_MERGE;
        end
        S_MERGE: begin
          i <= i_next;
          j <= j_next;
          k <= k_next;
          if (k_next == b_end) begin
            if (b_end == n_r) begin
              bank  <= ~bank;
              lo    <= '0;
              w     <= w2[msb_pkg::CNT_BITS-1:0];
              state <= (w2 >= sum_t'(n_r)) ? S_DONE : S_SETUP;
            end else begin
              lo    <= b_end;
              state <= S_SETUP;
            end
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_merge_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (i < a_end || j < b_end))
    else $error("merge step with both runs exhausted");

  a_merge_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (i <= a_end && j <= b_end && a_end <= b_end))
    else $error("merge pointer beyond its run");

  a_merge_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE) |-> (k == msb_pkg::cnt_t'(i + j - a_end)))
    else $error("write pointer out of step with run pointers");

endmodule

/* sv/merge_sort_block.sv */
// Stable ascending sort of a set of up to 64 unsigned 16-bit values. Values are
// taken one per cycle; the item marked final_item closes the set (values past
// the 64th are dropped, a final item still closes the set). The set is then
// sorted by bottom-up merge passes between two memory banks, and the sorted
// values come out one per cycle while results.ready is high, with last_out on
// the final one. No new input is taken until the last result is transferred.
// For a set of n values the sort takes ceil(log2 n) passes, each writing every
// value once, with a setup step before every pair of runs merged (n - 1 pairs
// in total over all passes for n a power of two). The sort speed is set by the
// single write port of the target bank, which takes one merged element per
// cycle.
module merge_sort_block (
  input  logic             clk,
  input  logic             rst,
  msb_in_if.sink           items,
  msb_out_if.source        results
);

  typedef enum logic [1:0] {T_LOAD, T_SORT, T_EMIT} state_t;

  state_t              state;
  msb_pkg::cnt_t       cnt;
  msb_pkg::cnt_t       n_r;
  msb_pkg::cnt_t       eidx;
  logic                res_bank;

  logic                xfer_in;
  logic                xfer_out;
  logic                full;
  logic                start;
  logic                last;
  msb_pkg::cnt_t       cnt_after;
  msb_pkg::cnt_t       eidx_next;
  logic                emit_rd;
  logic                emit_bank;

  msb_pkg::ram_req_t   req;
  msb_pkg::sort_stat_t stat;
  msb_pkg::value_t     eng_rdata_a;
  msb_pkg::value_t     eng_rdata_b;

  logic                we      [2];
  msb_pkg::idx_t       waddr   [2];
  msb_pkg::value_t     wdata   [2];
  msb_pkg::idx_t       raddr_a [2];
  msb_pkg::idx_t       raddr_b [2];
  msb_pkg::value_t     rdata_a [2];
  msb_pkg::value_t     rdata_b [2];

  // Handshake and load bookkeeping
  always_comb begin
    items.ready = (state == T_LOAD);
    xfer_in     = items.valid && items.ready;
    full        = (cnt == msb_pkg::cnt_t'(msb_pkg::DEPTH));
    cnt_after   = full ? cnt : cnt + msb_pkg::cnt_t'(1);
    start       = xfer_in && items.final_item;
  end

  // Output side: the result bank's read register is the output register
  always_comb begin
    results.valid        = (state == T_EMIT);
    xfer_out             = results.valid && results.ready;
    last                 = ((eidx + msb_pkg::cnt_t'(1)) == n_r);
    results.sorted_value = res_bank ? rdata_a[1] : rdata_a[0];
    results.last_out     = last;
    eidx_next            = xfer_out ? eidx + msb_pkg::cnt_t'(1) : eidx;
    emit_rd              = (state == T_EMIT) || ((state == T_SORT) && stat.done);
    emit_bank            = (state == T_EMIT) ? res_bank : stat.bank;
    if (state == T_SORT) begin
      eidx_next = '0;
    end
  end

  // Route engine reads from the source bank
  assign eng_rdata_a = stat.bank ? rdata_a[1] : rdata_a[0];
  assign eng_rdata_b = stat.bank ? rdata_b[1] : rdata_b[0];

  msb_merge u_merge (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .n       (cnt_after),
    .rdata_a (eng_rdata_a),
    .rdata_b (eng_rdata_b),
    .req     (req),
    .stat    (stat)
  );

  for (genvar b = 0; b < 2; b++) begin : g_bank
    // Bank 0 takes loads; during the sort the bank opposite the source is written
    always_comb begin
      we[b] = ((state == T_SORT) && req.wr_en && (stat.bank != 1'(b)))
           || ((b == 0) && (state == T_LOAD) && xfer_in && !full);
      waddr[b]   = (state == T_LOAD) ? cnt[msb_pkg::IDX_BITS-1:0] : req.wr_addr;
      wdata[b]   = (state == T_LOAD) ? items.value : req.wr_data;
      raddr_a[b] = (emit_rd && (emit_bank == 1'(b))) ?
                   eidx_next[msb_pkg::IDX_BITS-1:0] : req.rd_a;
      raddr_b[b] = req.rd_b;
    end

    msb_ram #(
      .DEPTH_P (msb_pkg::DEPTH),
      .WIDTH_P (msb_pkg::VALUE_BITS)
    ) u_ram (
      .clk     (clk),
      .we      (we[b]),
      .waddr   (waddr[b]),
      .wdata   (wdata[b]),
      .raddr_a (raddr_a[b]),
      .raddr_b (raddr_b[b]),
      .rdata_a (rdata_a[b]),
      .rdata_b (rdata_b[b])
    );
  end

  // Load, sort, emit sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_LOAD;
      cnt   <= '0;
    end else begin
      unique case (state)
        T_LOAD: begin
          if (xfer_in) begin
            if (items.final_item) begin
              n_r   <= cnt_after;
              cnt   <= '0;
              state <= T_SORT;
            end else if (!full) begin
              cnt <= cnt + msb_pkg::cnt_t'(1);
            end
          end
        end
        T_SORT: begin
          if (stat.done) begin
            res_bank <= stat.bank;
            eidx     <= '0;
            state    <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (xfer_out) begin
            if (last) begin
              state <= T_LOAD;
            end else begin
              eidx <= eidx + msb_pkg::cnt_t'(1);
            end
          end
        end
        default: begin
          state <= T_LOAD;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && results.valid))
    else $error("input taken while results are pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= msb_pkg::cnt_t'(msb_pkg::DEPTH))
    else $error("load count beyond store depth");

  a_done_in_sort: assert property (@(posedge clk) disable iff (rst)
    stat.done |-> (state == T_SORT))
    else $error("sort finished outside the sort phase");

endmodule
